### rtl/i2cm_pkg.sv
// Shared types and constants of the I2C byte-level master sequencer.
`default_nettype none
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = 3;
    localparam int CFG_W         = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int TDATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COND_HOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PULSE = 2'd2;

    localparam logic [CFG_W-1:0] COND_HOLD_RST   = 10'd60;
    localparam logic [CFG_W-1:0] DATA_SETUP_RST  = 10'd100;
    localparam logic [CFG_W-1:0] CLOCK_PULSE_RST = 10'd10;

    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_RECV  = 3'd4,
        CMD_GACK  = 3'd5,
        CMD_ASLOT = 3'd6
    } t_cmd;

    typedef struct packed {
        logic                     sda_in;
        logic [BITS_PER_BYTE-1:0] write_byte;
        logic [2:0]               command;
    } t_item;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] read_byte;
        logic                     done_res;
        logic                     busy_res;
        logic                     sda_out;
        logic                     scl_out;
    } t_result;

endpackage
`default_nettype wire

### rtl/i2cm_fifo.sv
// Two-entry queue with registered head, used on both sides of the sequencer.
`default_nettype none
module i2cm_fifo #(
    parameter int WIDTH = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic [WIDTH-1:0] r_head;
    logic [WIDTH-1:0] n_head;
    logic [WIDTH-1:0] r_tail;
    logic [WIDTH-1:0] n_tail;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        case (r_count)
            2'd0: begin
                if (w_push) begin
                    n_head  = i_data;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    n_head = i_data;
                end else if (w_push) begin
                    n_tail  = i_data;
                    n_count = 2'd2;
                end else if (w_pop) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (w_pop) begin
                    n_head  = r_tail;
                    n_count = 2'd1;
                end
            end
            default: begin
                n_count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |=> (r_count != 2'd2))
        else $error("Queue filled two entries in one cycle.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push && r_count == 2'd2) |=> (r_head == $past(r_tail)))
        else $error("Queue head did not advance to the second entry.");

endmodule
`default_nettype wire

### rtl/i2cm_seq.sv
// Bus sequencer that turns one tick item into the line levels and status of that tick.
`default_nettype none
module i2cm_seq #(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [i2cm_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                             i_step,
    input  wire i2cm_pkg::t_item                  i_item,
    output i2cm_pkg::t_result                     o_result
);

    localparam int HW = (COUNT_WIDTH > i2cm_pkg::CFG_W) ? COUNT_WIDTH : i2cm_pkg::CFG_W;
    localparam logic [HW-1:0] COUNT_MAX = HW'({COUNT_WIDTH{1'b1}});
    localparam int BYTE_MSB = i2cm_pkg::BITS_PER_BYTE - 1;

    logic [i2cm_pkg::CFG_W-1:0] r_cond_hold;
    logic [i2cm_pkg::CFG_W-1:0] r_data_setup;
    logic [i2cm_pkg::CFG_W-1:0] r_clock_pulse;

    i2cm_pkg::t_cmd                     r_act;
    i2cm_pkg::t_cmd                     n_act;
    logic [2:0]                         r_phase;
    logic [2:0]                         n_phase;
    logic [i2cm_pkg::BIT_W-1:0]         r_bit;
    logic [i2cm_pkg::BIT_W-1:0]         n_bit;
    logic [COUNT_WIDTH-1:0]             r_tc;
    logic [COUNT_WIDTH-1:0]             n_tc;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] r_shift;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] n_shift;
    logic                               r_scl;
    logic                               n_scl;
    logic                               r_sda;
    logic                               n_sda;

    logic                               v_done;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] v_rbyte;
    logic [i2cm_pkg::CFG_W-1:0]         v_hold;
    logic [HW-1:0]                      v_hold_ext;
    logic [COUNT_WIDTH-1:0]             v_tc1;
    logic                               v_last;

    always_comb begin
        n_act   = r_act;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_tc    = r_tc;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        v_done  = 1'b0;
        v_rbyte = '0;
        v_hold  = r_clock_pulse;
        v_hold_ext = '0;
        v_tc1   = '0;
        v_last  = 1'b0;

        if (r_act == i2cm_pkg::CMD_NONE && i_item.command >= i2cm_pkg::CMD_START
                && i_item.command <= i2cm_pkg::CMD_ASLOT) begin
            n_act   = i2cm_pkg::t_cmd'(i_item.command);
            n_bit   = '0;
            n_phase = i2cm_pkg::PH0;
            n_tc    = '0;
            if (n_act == i2cm_pkg::CMD_SEND) begin
                n_shift = i_item.write_byte;
            end else if (n_act == i2cm_pkg::CMD_RECV) begin
                n_shift = '0;
            end
            case (n_act)
                i2cm_pkg::CMD_START: begin
                    n_sda = 1'b1;
                end
                i2cm_pkg::CMD_STOP: begin
                    n_sda = 1'b0;
                end
                i2cm_pkg::CMD_GACK: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                default: begin
                    n_scl = 1'b0;
                end
            endcase
        end

        if (n_act != i2cm_pkg::CMD_NONE) begin
            v_tc1 = n_tc + COUNT_WIDTH'(1);
            case (n_act)
                i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
                    v_hold = r_cond_hold;
                end
                i2cm_pkg::CMD_SEND: begin
                    v_hold = (n_phase == i2cm_pkg::PH1) ? r_data_setup : r_clock_pulse;
                end
                i2cm_pkg::CMD_RECV, i2cm_pkg::CMD_ASLOT: begin
                    v_hold = (n_phase == i2cm_pkg::PH0) ? r_data_setup : r_clock_pulse;
                end
                default: begin
                    v_hold = r_clock_pulse;
                end
            endcase
            v_hold_ext = (v_hold == '0) ? HW'(1) : HW'(v_hold);
            if (v_hold_ext > COUNT_MAX) begin
                v_hold_ext = COUNT_MAX;
            end
            n_tc = v_tc1;
            if (HW'(v_tc1) >= v_hold_ext) begin
                v_last = (n_bit == i2cm_pkg::BIT_W'(BYTE_MSB));
                n_tc   = '0;
                case (n_act)
                    i2cm_pkg::CMD_START: begin
                        if (n_phase < i2cm_pkg::PH3) begin
                            n_phase = n_phase + 3'd1;
                            case (n_phase)
                                i2cm_pkg::PH1: n_scl = 1'b1;
                                i2cm_pkg::PH2: n_sda = 1'b0;
                                default:       n_scl = 1'b0;
                            endcase
                        end else begin
                            v_done = 1'b1;
                        end
                    end
                    i2cm_pkg::CMD_STOP: begin
                        if (n_phase < i2cm_pkg::PH3) begin
                            n_phase = n_phase + 3'd1;
                            case (n_phase)
                                i2cm_pkg::PH1: n_scl = 1'b1;
                                i2cm_pkg::PH2: n_sda = 1'b1;
                                default:       n_scl = 1'b0;
                            endcase
                        end else begin
                            v_done = 1'b1;
                        end
                    end
                    i2cm_pkg::CMD_SEND: begin
                        if (n_phase < i2cm_pkg::PH3) begin
                            n_phase = n_phase + 3'd1;
                            if (n_phase == i2cm_pkg::PH1) begin
                                n_sda = n_shift[BYTE_MSB];
                            end else begin
                                n_scl = (n_phase == i2cm_pkg::PH2);
                            end
                        end else begin
                            n_shift = {n_shift[BYTE_MSB-1:0], 1'b0};
                            if (v_last) begin
                                v_done = 1'b1;
                            end else begin
                                n_bit   = n_bit + i2cm_pkg::BIT_W'(1);
                                n_phase = i2cm_pkg::PH1;
                                n_sda   = n_shift[BYTE_MSB];
                            end
                        end
                    end
                    i2cm_pkg::CMD_RECV: begin
                        if (n_phase == i2cm_pkg::PH0) begin
                            n_shift = {n_shift[BYTE_MSB-1:0], i_item.sda_in};
                            n_phase = i2cm_pkg::PH1;
                            n_scl   = 1'b1;
                        end else begin
                            n_scl = 1'b0;
                            if (v_last) begin
                                n_sda  = 1'b1;
                                v_done = 1'b1;
                            end else begin
                                n_bit   = n_bit + i2cm_pkg::BIT_W'(1);
                                n_phase = i2cm_pkg::PH0;
                            end
                        end
                    end
                    i2cm_pkg::CMD_GACK: begin
                        if (n_phase == i2cm_pkg::PH0) begin
                            n_phase = i2cm_pkg::PH1;
                            n_scl   = 1'b1;
                        end else begin
                            n_scl  = 1'b0;
                            n_sda  = 1'b1;
                            v_done = 1'b1;
                        end
                    end
                    default: begin
                        if (n_phase == i2cm_pkg::PH0) begin
                            n_phase = i2cm_pkg::PH1;
                            n_scl   = 1'b1;
                        end else begin
                            n_scl  = 1'b0;
                            v_done = 1'b1;
                        end
                    end
                endcase
                if (v_done) begin
                    if (n_act == i2cm_pkg::CMD_RECV) begin
                        v_rbyte = n_shift;
                    end
                    n_act   = i2cm_pkg::CMD_NONE;
                    n_phase = i2cm_pkg::PH0;
                    n_bit   = '0;
                    n_tc    = '0;
                end
            end
        end

        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.busy_res  = (n_act != i2cm_pkg::CMD_NONE);
        o_result.done_res  = v_done;
        o_result.read_byte = v_rbyte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond_hold   <= i2cm_pkg::COND_HOLD_RST;
            r_data_setup  <= i2cm_pkg::DATA_SETUP_RST;
            r_clock_pulse <= i2cm_pkg::CLOCK_PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cm_pkg::CFG_COND_HOLD:   r_cond_hold   <= i_cfg_data;
                i2cm_pkg::CFG_DATA_SETUP:  r_data_setup  <= i_cfg_data;
                i2cm_pkg::CFG_CLOCK_PULSE: r_clock_pulse <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= i2cm_pkg::CMD_NONE;
            r_phase <= i2cm_pkg::PH0;
            r_bit   <= '0;
            r_tc    <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (i_step) begin
            r_act   <= n_act;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tc    <= n_tc;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.done_res) |=> (r_act == i2cm_pkg::CMD_NONE && r_phase == i2cm_pkg::PH0))
        else $error("Sequencer did not return to idle after completion.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act == i2cm_pkg::CMD_NONE) |-> (r_tc == '0 && r_bit == '0))
        else $error("Idle sequencer holds a stale counter.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_act) && $stable(r_tc) && $stable(r_shift) && $stable(r_scl)))
        else $error("Sequencer state moved without a tick.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.read_byte != '0) |-> o_result.done_res)
        else $error("Received byte shown outside a completion tick.");

endmodule
`default_nettype wire

### rtl/i2c_bit_level_master_top.sv
// Top level of the I2C byte-level master sequencer with its tick and result streams.
//
// Each transaction on the s_axis side is one timer tick carrying a command, a byte to
// send and the sampled SDA level; each tick yields exactly one result transaction on the
// m_axis side with the SCL and SDA drive levels, busy, done and the received byte.
// Commands arriving while a command is in progress are ignored, as is code 7.
// A two-entry input queue takes ticks, the sequencer consumes one per cycle while the
// output queue has room, and a two-entry output queue holds results, so one tick per
// cycle is sustained while m_axis_tready stays high. The three timing registers are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write them only
// while the block is idle, which the block does not enforce; an index beyond the list is ignored.
// Synchronous reset restores the timing registers to 60, 100 and 10 ticks, idles the
// sequencer with both lines released and empties both queues.
// When the result receiver stalls, the output queue fills, the sequencer holds its
// state, and s_axis_tready drops once the input queue is full; nothing is lost.
`default_nettype none
module i2c_bit_level_master_top #(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // command [2:0], write_byte [10:3], sda_in [11], zero [15:12]
    input  wire logic [i2cm_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // scl_out [0], sda_out [1], busy_res [2], done_res [3], read_byte [11:4], zero [15:12]
    output logic [i2cm_pkg::TDATA_W-1:0]        m_axis_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [i2cm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int ITEM_W = $bits(i2cm_pkg::t_item);
    localparam int RES_W  = $bits(i2cm_pkg::t_result);

    i2cm_pkg::t_item   w_in_item;
    i2cm_pkg::t_item   w_q_item;
    logic [ITEM_W-1:0] w_q_data;
    logic              w_q_valid;
    logic              w_res_ready;
    logic              w_step;
    i2cm_pkg::t_result w_result;
    logic [RES_W-1:0]  w_out_data;

    assign w_in_item = i2cm_pkg::t_item'(s_axis_tdata[ITEM_W-1:0]);
    assign w_q_item  = i2cm_pkg::t_item'(w_q_data);
    assign w_step    = w_q_valid && w_res_ready;

    i2cm_fifo #(
        .WIDTH(ITEM_W)
    ) u_in_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_data (w_in_item),
        .o_valid(w_q_valid),
        .i_ready(w_res_ready),
        .o_data (w_q_data)
    );

    i2cm_seq #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_step    (w_step),
        .i_item    (w_q_item),
        .o_result  (w_result)
    );

    i2cm_fifo #(
        .WIDTH(RES_W)
    ) u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_ready(w_res_ready),
        .i_data (w_result),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (w_out_data)
    );

    assign m_axis_tdata = {{(i2cm_pkg::TDATA_W - RES_W){1'b0}}, w_out_data};

endmodule
`default_nettype wire
